[hw/rtl/bsq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsq_pkg
// Shared types, codes and sizes of the bounded sorted queue.
// ----------------------------------------------------------------------------
package bsq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int KEY_WIDTH     = 16;
  localparam int DATA_WIDTH    = 32;
  localparam int POS_WIDTH     = 4;
  localparam int COUNT_WIDTH   = 5;
  localparam int CAP_WIDTH     = 5;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH = 5;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_PEEK  = 2'd2;
  localparam logic [1:0] CMD_FLUSH = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_NEW  = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_BAD_POS = 3'd4;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SORT_ENABLE = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_ASCENDING   = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_CAPACITY    = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_ACCEPT_NEW  = 2'd3;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [DATA_WIDTH-1:0] data_in;
    logic [KEY_WIDTH-1:0]  key_in;
    logic [POS_WIDTH-1:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [2:0]             status;
    logic [DATA_WIDTH-1:0]  data_out;
    logic [KEY_WIDTH-1:0]   key_out;
    logic [COUNT_WIDTH-1:0] count;
    logic                   is_empty;
  } out_item_t;

  typedef struct packed {
    logic                 sort_enable;
    logic                 ascending;
    logic [CAP_WIDTH-1:0] capacity;
    logic                 accept_new;
  } cfg_t;

  typedef struct packed {
    logic                  valid;
    logic                  is_push;
    logic                  is_pop;
    logic                  is_peek;
    logic                  is_flush;
    logic [DATA_WIDTH-1:0] data;
    logic [KEY_WIDTH-1:0]  key;
    logic [POS_WIDTH-1:0]  position;
  } op_t;

endpackage
`default_nettype wire

[hw/rtl/bsq_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsq_fifo
// Two-entry item queue with registered storage.
// ----------------------------------------------------------------------------
module bsq_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  logic [WIDTH-1:0] store [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       level;
  logic             do_wr;
  logic             do_rd;

  assign full    = (level == 2'd2);
  assign empty   = (level == 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_wr && !do_rd) begin
        level <= level + 2'd1;
      end else if (do_rd && !do_wr) begin
        level <= level - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/bsq_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsq_front
// Accepts items into a short queue and decodes the command of the oldest.
// ----------------------------------------------------------------------------
module bsq_front
  import bsq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t req,
  output logic     full,
  input  logic     op_take,
  output op_t      op
);

  in_item_t head;
  logic     q_empty;

  bsq_fifo #(
    .WIDTH($bits(in_item_t))
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push),
    .wr_data(req),
    .full   (full),
    .rd_en  (op_take),
    .rd_data(head),
    .empty  (q_empty)
  );

  always_comb begin
    op          = '0;
    op.valid    = !q_empty;
    op.data     = head.data_in;
    op.key      = head.key_in;
    op.position = head.position;
    unique case (head.cmd)
      CMD_PUSH:  op.is_push  = 1'b1;
      CMD_POP:   op.is_pop   = 1'b1;
      CMD_PEEK:  op.is_peek  = 1'b1;
      CMD_FLUSH: op.is_flush = 1'b1;
      default:   op.is_flush = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/bsq_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsq_back
// Entry cells head first; one decoded item per cycle while results have room.
// ----------------------------------------------------------------------------
module bsq_back
  import bsq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  op_t       op,
  output logic      op_take,
  input  logic      res_full,
  output logic      res_push,
  output out_item_t res
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int LIM_W = (CNT_W > CAP_WIDTH) ? CNT_W : CAP_WIDTH;
  localparam int PW    = (LIM_W > POS_WIDTH) ? LIM_W : POS_WIDTH;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [KEY_WIDTH-1:0]  cell_key  [DEPTH];
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;

  logic                  fire;
  logic [LIM_W-1:0]      cap_ext;
  logic [LIM_W-1:0]      limit;
  logic                  at_limit;
  logic [CNT_W-1:0]      slot_sorted;
  logic [CNT_W-1:0]      slot;
  logic                  do_push;
  logic                  do_pop;
  logic                  peek_ok;
  logic [IDX_W-1:0]      peek_idx;

  function automatic logic in_order(input logic [KEY_WIDTH-1:0] a,
                                    input logic [KEY_WIDTH-1:0] b,
                                    input logic                 asc);
    in_order = asc ? (a <= b) : (a >= b);
  endfunction

  assign fire     = op.valid && !res_full;
  assign op_take  = fire;
  assign res_push = fire;

  assign cap_ext  = LIM_W'(cfg.capacity);
  assign limit    = (cap_ext < LIM_W'(DEPTH)) ? cap_ext : LIM_W'(DEPTH);
  assign at_limit = LIM_W'(count) >= limit;

  always_comb begin
    slot_sorted = count;
    for (int i = DEPTH - 1; i >= 1; i--) begin
      if ((CNT_W'(i) < count) &&
          in_order(cell_key[i-1], op.key, cfg.ascending) &&
          in_order(op.key, cell_key[i], cfg.ascending)) begin
        slot_sorted = CNT_W'(i);
      end
    end
    if ((count != '0) && in_order(op.key, cell_key[0], cfg.ascending)) begin
      slot_sorted = '0;
    end
  end

  assign slot     = cfg.sort_enable ? slot_sorted : count;
  assign do_push  = fire && op.is_push && cfg.accept_new && !at_limit;
  assign do_pop   = fire && op.is_pop && (count != '0);
  assign peek_ok  = (PW'(op.position) < PW'(count)) && (PW'(op.position) < PW'(DEPTH));
  assign peek_idx = IDX_W'(op.position);

  always_comb begin
    count_next = count;
    if (op.is_flush) begin
      count_next = '0;
    end else if (do_push) begin
      count_next = count + CNT_W'(1);
    end else if (do_pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    res          = '0;
    res.status   = ST_OK;
    res.count    = COUNT_WIDTH'(count_next);
    res.is_empty = (count_next == '0);
    if (op.is_push) begin
      if (!cfg.accept_new) begin
        res.status = ST_NO_NEW;
      end else if (at_limit) begin
        res.status = ST_FULL;
      end
    end else if (op.is_pop) begin
      if (count == '0) begin
        res.status = ST_EMPTY;
      end else begin
        res.data_out = cell_data[0];
        res.key_out  = cell_key[0];
      end
    end else if (op.is_peek) begin
      if (!peek_ok) begin
        res.status = ST_BAD_POS;
      end else begin
        res.data_out = cell_data[peek_idx];
        res.key_out  = cell_key[peek_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    logic [DATA_WIDTH-1:0] up_data;
    logic [KEY_WIDTH-1:0]  up_key;
    logic [DATA_WIDTH-1:0] dn_data;
    logic [KEY_WIDTH-1:0]  dn_key;

    if (j == 0) begin : g_top
      assign up_data = cell_data[0];
      assign up_key  = cell_key[0];
    end else begin : g_mid
      assign up_data = cell_data[j-1];
      assign up_key  = cell_key[j-1];
    end

    if (j == DEPTH - 1) begin : g_last
      assign dn_data = cell_data[j];
      assign dn_key  = cell_key[j];
    end else begin : g_rest
      assign dn_data = cell_data[j+1];
      assign dn_key  = cell_key[j+1];
    end

    always_ff @(posedge clk) begin
      if (do_push) begin
        if (CNT_W'(j) == slot) begin
          cell_data[j] <= op.data;
          cell_key[j]  <= op.key;
        end else if (CNT_W'(j) > slot) begin
          cell_data[j] <= up_data;
          cell_key[j]  <= up_key;
        end
      end else if (do_pop) begin
        cell_data[j] <= dn_data;
        cell_key[j]  <= dn_key;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/bounded_sorted_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_sorted_queue
// Bounded queue of data handles with sort keys: push, pop, peek, flush.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on req while push is high and full is low. Every item
//   gives exactly one result on rsp, shown while empty is low and taken
//   with pop. Configuration is written through cfg_we, cfg_index, cfg_data
//   while no item is in flight.
// Path: an accepted item is registered in the item queue, the back end
//   executes it, and its result is registered in the result queue, from
//   which pop takes it.
// Throughput: one item per cycle while the result queue has room; the back
//   end executes a push, pop, peek or flush across all entry cells at once.
// Reset: the queue holds no entries; sort off, ascending, capacity 16,
//   pushes accepted.
// Stall: with pop low the two-entry result queue fills, the back end halts,
//   then the two-entry item queue fills and full rises.
// ----------------------------------------------------------------------------
module bounded_sorted_queue
  import bsq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  in_item_t                  req,
  output logic                      empty,
  input  logic                      pop,
  output out_item_t                 rsp,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

  cfg_t      cfg;
  op_t       op;
  logic      op_take;
  logic      res_full;
  logic      res_push;
  out_item_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sort_enable <= 1'b0;
      cfg.ascending   <= 1'b1;
      cfg.capacity    <= CAP_WIDTH'(16);
      cfg.accept_new  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SORT_ENABLE: cfg.sort_enable <= cfg_data[0];
        CFG_ASCENDING:   cfg.ascending   <= cfg_data[0];
        CFG_CAPACITY:    cfg.capacity    <= cfg_data[CAP_WIDTH-1:0];
        CFG_ACCEPT_NEW:  cfg.accept_new  <= cfg_data[0];
        default:         cfg.accept_new  <= cfg.accept_new;
      endcase
    end
  end

  bsq_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .req    (req),
    .full   (full),
    .op_take(op_take),
    .op     (op)
  );

  bsq_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .op      (op),
    .op_take (op_take),
    .res_full(res_full),
    .res_push(res_push),
    .res     (res)
  );

  bsq_fifo #(
    .WIDTH($bits(out_item_t))
  ) u_result (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_push),
    .wr_data(res),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(rsp),
    .empty  (empty)
  );

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded sorted queue. A driver offers items
// from a backlog filled phase by phase, an internal copy of the queue
// predicts each result at acceptance, and a monitor compares every result
// with the oldest prediction. Phases change sort mode, order, capacity and
// push acceptance while the block is idle, and vary sender and receiver
// idling, including a long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module testbench;
  import bsq_pkg::*;

  localparam int QDEPTH    = DEPTH_DEFAULT;
  localparam int MAX_CYCLE = 300000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      push = 1'b0;
  logic                      full;
  in_item_t                  req = '0;
  logic                      empty;
  logic                      pop = 1'b0;
  out_item_t                 rsp;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_WIDTH-1:0]  cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

  in_item_t              req_backlog[$];
  out_item_t             rsp_due[$];
  int                    send_idle_pct = 0;
  int                    pop_stall_pct = 0;
  logic                  hold_req = 1'b0;
  logic                  hold_req_q = 1'b0;
  int                    hold_left = 0;
  int                    errors = 0;
  int                    cycles = 0;

  logic [DATA_WIDTH-1:0] mdl_data[QDEPTH];
  logic [KEY_WIDTH-1:0]  mdl_key[QDEPTH];
  int                    mdl_count = 0;
  logic                  mdl_sort = 1'b0;
  logic                  mdl_asc = 1'b1;
  logic [CAP_WIDTH-1:0]  mdl_cap = 5'd16;
  logic                  mdl_accept = 1'b1;

  bounded_sorted_queue u_top (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .req(req),
    .empty(empty),
    .pop(pop),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int sorted_slot(logic [KEY_WIDTH-1:0] k);
    int i;
    if (mdl_count == 0) return 0;
    if (mdl_asc ? (mdl_key[0] >= k) : (mdl_key[0] <= k)) return 0;
    for (i = 0; i + 1 < mdl_count; i++) begin
      if (mdl_asc ? (mdl_key[i] <= k && k <= mdl_key[i+1])
                  : (mdl_key[i] >= k && k >= mdl_key[i+1]))
        return i + 1;
    end
    return mdl_count;
  endfunction

  function automatic out_item_t queue_apply(in_item_t it);
    out_item_t r;
    int        lim;
    int        slot;
    int        i;
    r = '0;
    r.status = ST_OK;
    lim = (int'(mdl_cap) < QDEPTH) ? int'(mdl_cap) : QDEPTH;
    case (it.cmd)
      CMD_PUSH: begin
        if (!mdl_accept) begin
          r.status = ST_NO_NEW;
        end else if (mdl_count >= lim) begin
          r.status = ST_FULL;
        end else begin
          slot = mdl_sort ? sorted_slot(it.key_in) : mdl_count;
          for (i = mdl_count; i > slot; i--) begin
            mdl_data[i] = mdl_data[i-1];
            mdl_key[i] = mdl_key[i-1];
          end
          mdl_data[slot] = it.data_in;
          mdl_key[slot] = it.key_in;
          mdl_count++;
        end
      end
      CMD_POP: begin
        if (mdl_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data_out = mdl_data[0];
          r.key_out = mdl_key[0];
          for (i = 0; i + 1 < mdl_count; i++) begin
            mdl_data[i] = mdl_data[i+1];
            mdl_key[i] = mdl_key[i+1];
          end
          mdl_count--;
        end
      end
      CMD_PEEK: begin
        if (int'(it.position) >= mdl_count) begin
          r.status = ST_BAD_POS;
        end else begin
          r.data_out = mdl_data[it.position];
          r.key_out = mdl_key[it.position];
        end
      end
      CMD_FLUSH: begin
        mdl_count = 0;
      end
      default: ;
    endcase
    r.count = mdl_count[COUNT_WIDTH-1:0];
    r.is_empty = (mdl_count == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) rsp_due.push_back(queue_apply(req));
      if (!push || !full) begin
        if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req <= req_backlog.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    hold_req_q <= hold_req;
    if (hold_req && !hold_req_q) hold_left <= 400;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (rsp_due.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: st=%0d data=%h key=%h",
                   $time, rsp.status, rsp.data_out, rsp.key_out);
        end else begin
          want = rsp_due.pop_front();
          if (rsp !== want) begin
            errors++;
            $display("%0t: mismatch expected st=%0d data=%h key=%h cnt=%0d emp=%0d",
                     $time, want.status, want.data_out, want.key_out, want.count,
                     want.is_empty);
            $display("%0t: mismatch actual   st=%0d data=%h key=%h cnt=%0d emp=%0d",
                     $time, rsp.status, rsp.data_out, rsp.key_out, rsp.count,
                     rsp.is_empty);
          end
        end
      end
      pop <= (hold_left == 0) && ($urandom_range(0, 99) >= pop_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLE) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void add_item(logic [1:0] c, logic [DATA_WIDTH-1:0] d,
                                   logic [KEY_WIDTH-1:0] k, logic [POS_WIDTH-1:0] p);
    in_item_t it;
    it.cmd = c;
    it.data_in = d;
    it.key_in = k;
    it.position = p;
    req_backlog.push_back(it);
  endfunction

  function automatic logic [KEY_WIDTH-1:0] rand_key();
    case ($urandom_range(0, 3))
      0: return KEY_WIDTH'($urandom_range(0, 7));
      1: return 16'hFFFF - KEY_WIDTH'($urandom_range(0, 7));
      default: return KEY_WIDTH'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic void add_random(int push_pct);
    int         roll;
    logic [1:0] c;
    roll = $urandom_range(0, 99);
    if (roll < 2) c = CMD_FLUSH;
    else if (roll < 2 + push_pct) c = CMD_PUSH;
    else if (roll < 17 + push_pct) c = CMD_PEEK;
    else c = CMD_POP;
    add_item(c, $urandom, rand_key(), POS_WIDTH'($urandom_range(0, 15)));
  endfunction

  task automatic wait_idle();
    while (req_backlog.size() != 0 || push || rsp_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_SORT_ENABLE: mdl_sort = val[0];
      CFG_ASCENDING:   mdl_asc = val[0];
      CFG_CAPACITY:    mdl_cap = val[CAP_WIDTH-1:0];
      CFG_ACCEPT_NEW:  mdl_accept = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int n, int push_pct, int s_idle, int r_stall, bit hold);
    int i;
    @(posedge clk);
    send_idle_pct <= s_idle;
    pop_stall_pct <= r_stall;
    if (hold) hold_req <= 1'b1;
    @(negedge clk);
    for (i = 0; i < n; i++) add_random(push_pct);
    wait_idle();
  endtask

  initial begin
    int i;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    add_item(CMD_POP, 32'h0, 16'h0, 4'd0);
    add_item(CMD_PEEK, 32'h0, 16'h0, 4'd0);
    add_item(CMD_PUSH, 32'hFFFF_FFFF, 16'hFFFF, 4'd0);
    add_item(CMD_PUSH, 32'h0, 16'h0, 4'd0);
    for (i = 2; i < QDEPTH; i++) add_item(CMD_PUSH, $urandom, rand_key(), 4'd0);
    add_item(CMD_PUSH, 32'hA5A5_5A5A, 16'h8000, 4'd0);
    add_item(CMD_PEEK, 32'h0, 16'h0, 4'd15);
    add_item(CMD_PEEK, 32'h0, 16'h0, 4'd0);
    add_item(CMD_POP, 32'h0, 16'h0, 4'd0);
    add_item(CMD_FLUSH, 32'hFFFF_FFFF, 16'hFFFF, 4'd15);
    add_item(CMD_PEEK, 32'h0, 16'h0, 4'd3);
    wait_idle();

    write_reg(CFG_SORT_ENABLE, 5'd1);
    run_phase(110, 70, 0, 0, 1'b0);
    write_reg(CFG_ASCENDING, 5'd0);
    write_reg(CFG_CAPACITY, 5'd5);
    run_phase(100, 55, 70, 0, 1'b0);
    write_reg(CFG_SORT_ENABLE, 5'd0);
    write_reg(CFG_ASCENDING, 5'd1);
    write_reg(CFG_CAPACITY, 5'd1);
    run_phase(70, 50, 0, 70, 1'b0);
    write_reg(CFG_ACCEPT_NEW, 5'd0);
    write_reg(CFG_SORT_ENABLE, 5'd1);
    run_phase(40, 60, 22, 22, 1'b0);
    write_reg(CFG_ACCEPT_NEW, 5'd1);
    write_reg(CFG_CAPACITY, 5'd0);
    run_phase(30, 60, 0, 0, 1'b0);
    write_reg(CFG_CAPACITY, 5'd31);
    write_reg(CFG_SORT_ENABLE, 5'd0);
    run_phase(90, 75, 22, 22, 1'b0);
    write_reg(CFG_SORT_ENABLE, 5'd1);
    run_phase(100, 55, 0, 0, 1'b0);
    write_reg(CFG_CAPACITY, 5'd16);
    run_phase(110, 50, 0, 22, 1'b1);

    repeat (8) @(posedge clk);
    @(negedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/bsq_pkg.sv
hw/rtl/bsq_fifo.sv
hw/rtl/bsq_front.sv
hw/rtl/bsq_back.sv
hw/rtl/bounded_sorted_queue.sv
tb/sv/testbench.sv
